### hdl/ctom_pkg.sv
// Package for the chip temperature overheat monitor.
// Holds calibration constants, register indexes and the structs shared by the front end,
// queue and back end. No dependencies.
package ctom_pkg;

  localparam int unsigned CalMv     = 3300;
  localparam int unsigned DenScale  = 165;
  localparam int unsigned NumShift  = 10;
  localparam int unsigned QuoBits   = 17;
  localparam int unsigned CntW      = $clog2(QuoBits);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned PtrW      = $clog2(QDepth);

  localparam logic signed [16:0] TempOffset = 17'sd7680;
  localparam logic [17:0]        NegLimit   = 18'd17920;
  localparam logic [17:0]        PosLimit   = 18'd30720;

  localparam logic [2:0] CfgCalLow    = 3'd0;
  localparam logic [2:0] CfgCalHigh   = 3'd1;
  localparam logic [2:0] CfgWarnLevel = 3'd2;
  localparam logic [2:0] CfgClrLevel  = 3'd3;
  localparam logic [2:0] CfgRaiseDly  = 3'd4;
  localparam logic [2:0] CfgDropDly   = 3'd5;

  localparam logic [15:0]        RstCalLow    = 16'd0;
  localparam logic [15:0]        RstCalHigh   = 16'd0;
  localparam logic signed [16:0] RstWarnLevel = 17'sd15360;
  localparam logic signed [16:0] RstClrLevel  = 17'sd14080;
  localparam logic [15:0]        RstRaiseDly  = 16'd2000;
  localparam logic [15:0]        RstDropDly   = 16'd0;

  typedef struct packed {
    logic [15:0]        cal_low_count;
    logic [15:0]        cal_high_count;
    logic signed [16:0] warn_level;
    logic signed [16:0] clear_level;
    logic [15:0]        raise_delay_ms;
    logic [15:0]        drop_delay_ms;
  } ctom_cfg_t;

  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [31:0] num_abs;
    logic [23:0] den;
    logic [31:0] now_ms;
  } ctom_item_t;

  typedef enum logic [2:0] {
    BackIdle,
    BackDiv,
    BackRound,
    BackFilt,
    BackQual
  } ctom_back_state_e;

endpackage

### hdl/ctom_front.sv
// Front end: accepts checks, screens sample and calibration, forms the conversion
// numerator magnitude, sign and denominator over two pipeline stages. Uses ctom_pkg.
module ctom_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctom_pkg::ctom_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  sample_present_i,
  input  logic [15:0]           raw_sample_i,
  input  logic [15:0]           adc_full_scale_i,
  input  logic [15:0]           vref_mv_i,
  input  logic [31:0]           now_ms_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output ctom_pkg::ctom_item_t  item_o
);
  import ctom_pkg::*;

  logic        s1_valid_q;
  logic        s1_ok_q;
  logic [31:0] s1_rv_q;
  logic [27:0] s1_cl_q;
  logic [15:0] s1_dabs_q;
  logic        s1_dneg_q;
  logic [31:0] s1_now_q;

  logic        s2_valid_q;
  ctom_item_t  s2_item_q;

  logic        s1_ready;
  logic        s2_ready;
  logic [15:0] vref_eff;
  logic        ok_in;
  logic        cal_ok;
  logic        pneg;
  logic [31:0] pabs;
  logic [23:0] den;

  assign s2_ready   = !s2_valid_q || item_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign vref_eff = (vref_mv_i == 16'd0) ? 16'(CalMv) : vref_mv_i;
  assign cal_ok   = (cfg_i.cal_low_count != 16'd0) && (cfg_i.cal_low_count != 16'hFFFF)
                 && (cfg_i.cal_high_count != 16'd0) && (cfg_i.cal_high_count != 16'hFFFF)
                 && (cfg_i.cal_low_count != cfg_i.cal_high_count);
  assign ok_in    = sample_present_i && (adc_full_scale_i != 16'd0) && (raw_sample_i != 16'd0)
                 && (raw_sample_i < adc_full_scale_i) && cal_ok;

  assign pneg = s1_rv_q < 32'(s1_cl_q);
  assign pabs = pneg ? (32'(s1_cl_q) - s1_rv_q) : (s1_rv_q - 32'(s1_cl_q));
  assign den  = 24'(s1_dabs_q) * 24'(DenScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_ok_q   <= ok_in;
      s1_rv_q   <= 32'(raw_sample_i) * 32'(vref_eff);
      s1_cl_q   <= 28'(cfg_i.cal_low_count) * 28'(CalMv);
      s1_dneg_q <= cfg_i.cal_high_count < cfg_i.cal_low_count;
      s1_dabs_q <= (cfg_i.cal_high_count < cfg_i.cal_low_count)
                 ? (cfg_i.cal_low_count - cfg_i.cal_high_count)
                 : (cfg_i.cal_high_count - cfg_i.cal_low_count);
      s1_now_q  <= now_ms_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_item_q.ok      <= s1_ok_q;
      s2_item_q.neg     <= pneg ^ s1_dneg_q;
      s2_item_q.num_abs <= pabs;
      s2_item_q.den     <= den;
      s2_item_q.now_ms  <= s1_now_q;
    end
  end

  assign item_valid_o = s2_valid_q;
  assign item_o       = s2_item_q;

endmodule

### hdl/ctom_queue.sv
// Short queue between front end and back end so each side stalls on its own.
// Uses ctom_pkg for the item type and depth.
module ctom_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  ctom_pkg::ctom_item_t  push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output ctom_pkg::ctom_item_t  pop_item_o
);
  import ctom_pkg::*;

  ctom_item_t      mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != (PtrW + 1)'(QDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/ctom_back.sv
// Back end: serial rounding divider, range check, exponential filter, threshold
// hysteresis and timed qualifier, with the result register. Uses ctom_pkg.
module ctom_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctom_pkg::ctom_cfg_t   cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  ctom_pkg::ctom_item_t  item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  temperature_valid_o,
  output logic signed [16:0]    filtered_temperature_o,
  output logic                  overheat_o
);
  import ctom_pkg::*;

  ctom_back_state_e   state_q, state_d;
  logic               ok_q, ok_d;
  logic               neg_q, neg_d;
  logic [41:0]        rem_q, rem_d;
  logic [40:0]        dsh_q, dsh_d;
  logic [23:0]        den_q, den_d;
  logic [16:0]        quo_q, quo_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [31:0]        now_q, now_d;
  logic signed [16:0] temp_q, temp_d;
  logic signed [16:0] filt_q, filt_d;
  logic               primed_q, primed_d;
  logic               ovh_q, ovh_d;
  logic               reqst_q, reqst_d;
  logic [31:0]        reqtime_q, reqtime_d;
  logic               out_valid_q, out_valid_d;
  logic               out_tv_q, out_tv_d;
  logic signed [16:0] out_temp_q, out_temp_d;
  logic               out_ovh_q, out_ovh_d;

  logic [41:0]        num;
  logic               ovf;
  logic               ge;
  logic               rnd;
  logic [17:0]        qr;
  logic               in_range;
  logic signed [17:0] diff;
  logic signed [17:0] step;
  logic               req;
  logic [31:0]        elapsed;
  logic [15:0]        need;
  logic               slot_free;

  assign num       = {item_i.num_abs, NumShift'(0)};
  assign ovf       = num >= {1'b0, item_i.den, 17'd0};
  assign ge        = rem_q >= {1'b0, dsh_q};
  assign rnd       = {rem_q[23:0], 1'b0} >= {1'b0, den_q};
  assign qr        = {1'b0, quo_q} + 18'(rnd);
  assign in_range  = neg_q ? (qr < NegLimit) : (qr < PosLimit);
  assign diff      = {temp_q[16], temp_q} - {filt_q[16], filt_q};
  assign step      = diff >>> 2;
  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_ready_o = state_q == BackIdle;

  always_comb begin
    state_d     = state_q;
    ok_d        = ok_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    den_d       = den_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    now_d       = now_q;
    temp_d      = temp_q;
    filt_d      = filt_q;
    primed_d    = primed_q;
    ovh_d       = ovh_q;
    reqst_d     = reqst_q;
    reqtime_d   = reqtime_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_tv_d    = out_tv_q;
    out_temp_d  = out_temp_q;
    out_ovh_d   = out_ovh_q;
    req         = 1'b0;
    elapsed     = '0;
    need        = '0;
    unique case (state_q)
      BackIdle: begin
        if (pop_valid_i) begin
          ok_d    = item_i.ok && !ovf;
          neg_d   = item_i.neg;
          rem_d   = num;
          dsh_d   = {1'b0, item_i.den, 16'd0};
          den_d   = item_i.den;
          quo_d   = '0;
          cnt_d   = '0;
          now_d   = item_i.now_ms;
          state_d = (item_i.ok && !ovf) ? BackDiv : BackFilt;
        end
      end
      BackDiv: begin
        if (ge) begin
          rem_d = rem_q - {1'b0, dsh_q};
        end
        quo_d = {quo_q[15:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(QuoBits - 1)) begin
          state_d = BackRound;
        end
      end
      BackRound: begin
        ok_d    = in_range;
        temp_d  = neg_q ? (TempOffset - $signed(qr[16:0])) : (TempOffset + $signed(qr[16:0]));
        state_d = BackFilt;
      end
      BackFilt: begin
        if (!ok_q) begin
          filt_d   = '0;
          primed_d = 1'b0;
        end else if (!primed_q) begin
          filt_d   = temp_q;
          primed_d = 1'b1;
        end else begin
          filt_d = filt_q + $signed(step[16:0]);
        end
        state_d = BackQual;
      end
      BackQual: begin
        if (slot_free) begin
          req = ok_q && (ovh_q ? ($signed(filt_q) > $signed(cfg_i.clear_level))
                               : ($signed(filt_q) >= $signed(cfg_i.warn_level)));
          if (req != ovh_q) begin
            if (req != reqst_q) begin
              reqst_d   = req;
              reqtime_d = now_q;
            end
          end else begin
            reqst_d = ovh_q;
          end
          elapsed = now_q - reqtime_d;
          need    = ovh_q ? cfg_i.drop_delay_ms : cfg_i.raise_delay_ms;
          if ((reqst_d != ovh_q) && (elapsed >= {16'd0, need})) begin
            ovh_d = reqst_d;
          end
          out_valid_d = 1'b1;
          out_tv_d    = ok_q;
          out_temp_d  = filt_q;
          out_ovh_d   = ovh_d;
          state_d     = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      filt_q      <= '0;
      primed_q    <= 1'b0;
      ovh_q       <= 1'b0;
      reqst_q     <= 1'b0;
      reqtime_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filt_q      <= filt_d;
      primed_q    <= primed_d;
      ovh_q       <= ovh_d;
      reqst_q     <= reqst_d;
      reqtime_q   <= reqtime_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q       <= ok_d;
    neg_q      <= neg_d;
    rem_q      <= rem_d;
    dsh_q      <= dsh_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    now_q      <= now_d;
    temp_q     <= temp_d;
    out_tv_q   <= out_tv_d;
    out_temp_q <= out_temp_d;
    out_ovh_q  <= out_ovh_d;
  end

  assign out_valid_o            = out_valid_q;
  assign temperature_valid_o    = out_tv_q;
  assign filtered_temperature_o = out_temp_q;
  assign overheat_o             = out_ovh_q;

endmodule

### hdl/chip_temperature_overheat_monitor.sv
// Chip temperature overheat monitor, top level: configuration registers, front end,
// queue and back end. Depends on ctom_pkg, ctom_front, ctom_queue and ctom_back.
// The back end takes one check at a time; its 17-step serial divider sets the throughput,
// and rejected checks skip the divider and rounding steps in the back end.
// The front end and queue hold up to four more checks.
// Reset clears filter, qualifier state and all handshake state; config registers take defaults.
module chip_temperature_overheat_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // raw_sample, adc_full_scale, vref_mv, now_ms
  input  logic [0:0]  s_axis_tuser,   // sample_present
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // filtered_temperature, overheat, zero pad
  output logic [0:0]  m_axis_tuser,   // temperature_valid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import ctom_pkg::*;

  ctom_cfg_t          cfg_q;
  logic               item_valid;
  logic               item_ready;
  ctom_item_t         front_item;
  logic               pop_valid;
  logic               pop_ready;
  ctom_item_t         pop_item;
  logic               temperature_valid;
  logic signed [16:0] filtered_temperature;
  logic               overheat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_low_count  <= RstCalLow;
      cfg_q.cal_high_count <= RstCalHigh;
      cfg_q.warn_level     <= RstWarnLevel;
      cfg_q.clear_level    <= RstClrLevel;
      cfg_q.raise_delay_ms <= RstRaiseDly;
      cfg_q.drop_delay_ms  <= RstDropDly;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCalLow:    cfg_q.cal_low_count  <= cfg_data_i[15:0];
        CfgCalHigh:   cfg_q.cal_high_count <= cfg_data_i[15:0];
        CfgWarnLevel: cfg_q.warn_level     <= $signed(cfg_data_i);
        CfgClrLevel:  cfg_q.clear_level    <= $signed(cfg_data_i);
        CfgRaiseDly:  cfg_q.raise_delay_ms <= cfg_data_i[15:0];
        CfgDropDly:   cfg_q.drop_delay_ms  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ctom_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .sample_present_i (s_axis_tuser[0]),
    .raw_sample_i     (s_axis_tdata[15:0]),
    .adc_full_scale_i (s_axis_tdata[31:16]),
    .vref_mv_i        (s_axis_tdata[47:32]),
    .now_ms_i         (s_axis_tdata[79:48]),
    .item_valid_o     (item_valid),
    .item_ready_i     (item_ready),
    .item_o           (front_item)
  );

  ctom_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (item_valid),
    .push_ready_o (item_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ctom_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .pop_valid_i            (pop_valid),
    .pop_ready_o            (pop_ready),
    .item_i                 (pop_item),
    .out_valid_o            (m_axis_tvalid),
    .out_ready_i            (m_axis_tready),
    .temperature_valid_o    (temperature_valid),
    .filtered_temperature_o (filtered_temperature),
    .overheat_o             (overheat)
  );

  assign m_axis_tdata = {6'd0, overheat, filtered_temperature};
  assign m_axis_tuser = temperature_valid;

endmodule

### hdl/ctom_checker.sv
// Port-level checks for the chip temperature overheat monitor, bound to the top level.
// Depends only on the top level's ports.
module ctom_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic [3:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 4'd0)
    else $error("result transfer without an outstanding check");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[16:0] == 17'd0)
    else $error("rejected check carries a nonzero temperature");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      ($signed(m_axis_tdata[16:0]) > -17'sd10240) && ($signed(m_axis_tdata[16:0]) < 17'sd38400))
    else $error("filtered temperature out of range");

endmodule

bind chip_temperature_overheat_monitor ctom_sva u_ctom_sva (.*);
